/* hdl/tcmc_pkg.sv */
// Shared types, constants and the percent-to-duty function for the throttle curve motor command block.
package tcmc_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam logic [14:0] DUTY_FULL = 15'd25600;
   localparam logic [7:0]  CUT_OFF = 8'd50;
   localparam logic [6:0]  DUTY_MIN_PCT = 7'd8;

   typedef enum logic [1:0] {
      MODE_STEP   = 2'd0,
      MODE_CURVE  = 2'd1,
      MODE_LINEAR = 2'd2
   } mode_type;

   typedef struct packed {
      logic [7:0] duty_limit;
      logic [7:0] left_magnitude;
      logic [7:0] right_magnitude;
      logic [5:0] direction_flags;
   } req_type;

   typedef struct packed {
      logic [14:0] left_duty;
      logic        left_dir_pin;
      logic [14:0] right_duty;
      logic        right_dir_pin;
   } rsp_type;

   // Classified item passed from front to back.
   typedef struct packed {
      mode_type   mode;
      logic [7:0] limit;
      logic [7:0] left_mag;
      logic [7:0] right_mag;
      logic       left_on;
      logic       left_pin;
      logic       right_on;
      logic       right_pin;
   } cmd_type;

   // Percent to duty, clamped at full scale.
   function automatic logic [14:0] pct_to_duty(input logic [9:0] p);
      logic [14:0] r;
      if (p >= 10'd100) r = DUTY_FULL;
      else r = {p[6:0], 8'd0};
      return r;
   endfunction

endpackage

/* hdl/tcmc_front.sv */
// Front end: accepts commands, decodes mode and direction, pushes into the queue.
module tcmc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  tcmc_pkg::req_type req_data,
   input  logic              q_full,
   output logic              busy,
   output logic              push,
   output tcmc_pkg::cmd_type push_cmd
);
   import tcmc_pkg::*;

   logic [5:0] fl;

   assign busy = q_full;
   assign push = start && !q_full;
   assign fl   = req_data.direction_flags;

   // Classify mode and direction
   always_comb begin
      push_cmd.mode = fl[2] ? MODE_LINEAR : (fl[1] ? MODE_CURVE : MODE_STEP);
      push_cmd.limit = req_data.duty_limit;
      push_cmd.left_mag = req_data.left_magnitude;
      push_cmd.right_mag = req_data.right_magnitude;
      push_cmd.left_on = fl[3] | fl[0];
      push_cmd.left_pin = fl[3] | ~fl[0];
      push_cmd.right_on = fl[5] | fl[4];
      push_cmd.right_pin = fl[5] | ~fl[4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
      end else begin
         assert (!(push && q_full)) else $error("push while queue full");
      end
   end
endmodule

/* hdl/tcmc_queue.sv */
// Short queue between the front and back ends.
module tcmc_queue #(
   parameter int unsigned DEPTH = tcmc_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tcmc_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output tcmc_pkg::cmd_type pop_cmd
);
   import tcmc_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cmd_type        mem_ff [DEPTH];
   logic [AW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]    cnt_ff, cnt_in;
   logic           do_pop;

   assign full      = (cnt_ff == (AW+1)'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign do_pop    = pop && not_empty;
   assign pop_cmd   = mem_ff[rd_ff];

   // Advance pointers
   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) wr_in = (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      if (do_pop) rd_in = (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_cmd;
   end

   ap_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(DEPTH)) else $error("queue count overflow");
   ap_no_over: assert property (@(posedge clock) disable iff (reset)
      full && !do_pop |=> cnt_ff == (AW+1)'(DEPTH)) else $error("full queue lost item");
   ap_pop_dec: assert property (@(posedge clock) disable iff (reset)
      do_pop && !push |=> cnt_ff == $past(cnt_ff) - 1'b1) else $error("pop count");
endmodule

/* hdl/tcmc_motor_duty.sv */
// Two-stage duty pipeline for one motor: products in stage one, divide and clamp in stage two.
module tcmc_motor_duty (
   input  logic              clock,
   input  tcmc_pkg::mode_type mode,
   input  logic [7:0]        limit,
   input  logic [7:0]        mag,
   input  logic              on,
   output logic [14:0]       duty
);
   import tcmc_pkg::*;

   // Reciprocals for the constant divides; exact over the 24-bit numerator and 11-bit step
   localparam logic [23:0] RECIP_205   = 24'd10475530;   // ceil(2^31 / 205)
   localparam logic [23:0] RECIP_66300 = 24'd16583886;   // ceil(2^40 / 66300)
   localparam logic [24:0] RECIP_850   = 25'd20211611;   // ceil(2^34 / 850)
   localparam logic [24:0] RECIP_1700  = 25'd20211611;   // ceil(2^35 / 1700)
   localparam logic [11:0] RECIP_3     = 12'd1366;       // ceil(2^12 / 3)

   // Stage 1 registers
   logic        zero_ff, zero_in;
   mode_type    mode_ff;
   logic [1:0]  seg_ff, seg_in;
   logic [23:0] num_ff, num_in;
   logic [10:0] step_ff, step_in;

   logic [21:0] d1k, l255;
   logic [23:0] d10k, l19125, l22950, l2550;
   logic [17:0] d440, l561;
   logic [19:0] d2200, l3927;
   logic [2:0]  k;
   logic [7:0]  dm;

   always_comb begin
      d1k    = 22'(mag) * 22'd1000;
      l255   = 22'(limit) * 22'd255;
      d10k   = 24'(mag) * 24'd10000;
      l19125 = 24'(limit) * 24'd19125;
      l22950 = 24'(limit) * 24'd22950;
      l2550  = 24'(limit) * 24'd2550;
      d440   = 18'(mag) * 18'd440;
      l561   = 18'(limit) * 18'd561;
      d2200  = 20'(mag) * 20'd2200;
      l3927  = 20'(limit) * 20'd3927;
      // Step index is the magnitude over 51
      k = (mag == 8'd255) ? 3'd5 : (mag >= 8'd204) ? 3'd4 : (mag >= 8'd153) ? 3'd3 :
          (mag >= 8'd102) ? 3'd2 : (mag >= 8'd51) ? 3'd1 : 3'd0;
      dm = mag - CUT_OFF;
      zero_in = !on || (mag <= CUT_OFF) ||
                ((mode != MODE_LINEAR) && (limit == 8'd0));
      seg_in = 2'd0;
      num_in = 24'(dm) * 24'd23552;
      step_in = 11'(k) * 11'(limit);
      // Pick curve segment and its numerator
      if (mode == MODE_CURVE) begin
         if (d1k < l255) begin
            seg_in = 2'd0; num_in = '0;
         end else if (d10k < l19125) begin
            seg_in = 2'd1; num_in = d10k - l2550;
         end else if (d10k < l22950) begin
            seg_in = 2'd2; num_in = 24'(d440 - l561);
         end else begin
            seg_in = 2'd3; num_in = 24'(d2200 - l3927);
         end
      end
   end

   always_ff @(posedge clock) begin
      zero_ff <= zero_in;
      mode_ff <= mode;
      seg_ff <= seg_in;
      num_ff <= num_in;
      step_ff <= step_in;
   end

   // Stage 2: constant divides by reciprocal multiply, then clamp
   logic [14:0] duty_in;
   logic [9:0]  p;
   logic [15:0] lin;
   logic [47:0] prod_lin, prod_s1;
   logic [48:0] prod_s2, prod_s3;
   logic [20:0] step_prod;
   always_comb begin
      prod_lin  = 48'(num_ff) * 48'(RECIP_205);
      prod_s1   = 48'(num_ff) * 48'(RECIP_66300);
      prod_s2   = 49'(num_ff) * 49'(RECIP_850);
      prod_s3   = 49'(num_ff) * 49'(RECIP_1700);
      step_prod = 21'(step_ff) * 21'(RECIP_3);
      p = '0;
      lin = 16'd2048 + 16'(prod_lin[45:31]);
      duty_in = '0;
      if (!zero_ff) begin
         unique case (mode_ff)
            MODE_LINEAR: duty_in = (lin > 16'(DUTY_FULL)) ? DUTY_FULL : lin[14:0];
            MODE_CURVE: begin
               case (seg_ff)
                  2'd1: begin
                     p = {2'b00, prod_s1[47:40]};
                     if (p < 10'(DUTY_MIN_PCT)) p = '0;
                  end
                  2'd2: p = prod_s2[43:34];
                  2'd3: p = prod_s3[44:35];
                  default: p = '0;
               endcase
               duty_in = pct_to_duty(p);
            end
            default: duty_in = pct_to_duty({1'b0, step_prod[20:12]});
         endcase
      end
   end

   always_ff @(posedge clock) duty <= duty_in;
endmodule

/* hdl/tcmc_back.sv */
// Back end: pops queued commands, computes both motor duties, drives the result strobe.
module tcmc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              not_empty,
   input  tcmc_pkg::cmd_type pop_cmd,
   output logic              pop,
   output logic              rsp_valid,
   output tcmc_pkg::rsp_type rsp_data
);
   import tcmc_pkg::*;

   logic [1:0]  vld_ff, vld_in;
   logic [1:0]  lpin_ff, rpin_ff;
   logic [14:0] lduty, rduty;

   assign pop = not_empty;
   assign vld_in = {vld_ff[0], pop};

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= vld_in;
   end

   // Carry pin levels alongside the duty pipeline
   always_ff @(posedge clock) begin
      lpin_ff <= {lpin_ff[0], pop_cmd.left_pin};
      rpin_ff <= {rpin_ff[0], pop_cmd.right_pin};
   end

   tcmc_motor_duty u_left (.clock, .mode(pop_cmd.mode), .limit(pop_cmd.limit),
      .mag(pop_cmd.left_mag), .on(pop_cmd.left_on), .duty(lduty));
   tcmc_motor_duty u_right (.clock, .mode(pop_cmd.mode), .limit(pop_cmd.limit),
      .mag(pop_cmd.right_mag), .on(pop_cmd.right_on), .duty(rduty));

   assign rsp_valid = vld_ff[1];
   assign rsp_data = '{left_duty: lduty, left_dir_pin: lpin_ff[1],
                       right_duty: rduty, right_dir_pin: rpin_ff[1]};

   ap_valid: assert property (@(posedge clock) disable iff (reset)
      pop |=> ##1 rsp_valid) else $error("popped item not delivered");
   ap_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> lduty <= DUTY_FULL && rduty <= DUTY_FULL) else $error("duty above full");
   ap_none: assert property (@(posedge clock) disable iff (reset)
      !$past(pop, 2) && !$past(reset, 2) |-> !rsp_valid) else $error("invented result");
endmodule

/* hdl/throttle_curve_motor_command.sv */
// Top level of the throttle curve motor command block.
// An accepted start is registered in the queue, then in the product stage and the divide stage before rsp_valid.
// Throughput: one item per cycle; the back end pops whenever the queue is not empty, so busy stays low.
// The receiver cannot stall; each result is shown for one cycle on rsp_valid.
// Reset (synchronous, active high) empties the queue and clears the valid pipeline.
module throttle_curve_motor_command #(
   parameter int unsigned QUEUE_DEPTH = tcmc_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tcmc_pkg::req_type req_data,
   output logic              rsp_valid,
   output tcmc_pkg::rsp_type rsp_data
);
   import tcmc_pkg::*;

   logic    push, pop, q_full, q_not_empty;
   cmd_type push_cmd, pop_cmd;

   tcmc_front u_front (.clock, .reset, .start, .req_data, .q_full, .busy, .push, .push_cmd);

   tcmc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (.clock, .reset, .push, .push_cmd, .pop,
      .full(q_full), .not_empty(q_not_empty), .pop_cmd);

   tcmc_back u_back (.clock, .reset, .not_empty(q_not_empty), .pop_cmd, .pop,
      .rsp_valid, .rsp_data);
endmodule
